// ----- hdl/iss_pkg.sv -----
// ----------------------------------------------------------------------------
// iss_pkg: shared constants for the indexed sequence store
// Sizes of the element store and the codes of the request actions and
// of the result status.
// ----------------------------------------------------------------------------
`default_nettype none

package iss_pkg;

  localparam int CAPACITY = 1024;
  localparam int ELEM_W   = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 16;
  localparam int ACT_W    = 4;
  localparam int STAT_W   = 2;

  // Request actions.
  localparam logic [ACT_W-1:0] ACT_INSERT_AT = 4'd0;
  localparam logic [ACT_W-1:0] ACT_READ      = 4'd1;
  localparam logic [ACT_W-1:0] ACT_WRITE     = 4'd2;
  localparam logic [ACT_W-1:0] ACT_DELETE    = 4'd3;
  localparam logic [ACT_W-1:0] ACT_PUSH_HEAD = 4'd4;
  localparam logic [ACT_W-1:0] ACT_PUSH_TAIL = 4'd5;
  localparam logic [ACT_W-1:0] ACT_POP_HEAD  = 4'd6;
  localparam logic [ACT_W-1:0] ACT_POP_TAIL  = 4'd7;
  localparam logic [ACT_W-1:0] ACT_SORTED    = 4'd8;

  // Result status.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

endpackage

`default_nettype wire

// ----- hdl/indexed_sequence_store_core.sv -----
// ----------------------------------------------------------------------------
// indexed_sequence_store_core: ordered word store with deque and indexed access
// Write, push tail, appends, no-ops and errors need no RAM read; read and pop
// tail read one entry; pop head and delete move the entries above down a slot;
// insert and push head move the entries at and above the slot up; sorted insert
// moves only the larger entries. One request in flight; the next is taken the
// cycle after its result is loaded. Shifts move one entry a cycle through the RAM.
// Reset clears the count and the output valid; entries are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_sequence_store_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [47:0] in_tdata,   // position[15:0], operand[47:16]
  input  wire logic [3:0]  in_tuser,   // action[3:0]
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [47:0] out_tdata,  // data_out[31:0], count[42:32], zero fill
  output      logic [1:0]  out_tuser   // status[1:0]
);

  import iss_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SHUP = 3'd1;
  localparam logic [2:0] S_PUT  = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_SHDN = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]        state_r, state_nxt;
  cnt_t              cnt_r, cnt_nxt;
  logic [ACT_W-1:0]  act_r, act_nxt;
  elem_t             val_r, val_nxt;
  addr_t             put_addr_r, put_addr_nxt;
  elem_t             data_r, data_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  addr_t             rd_addr_r;

  logic              out_valid_r;
  elem_t             out_data_r;
  cnt_t              out_cnt_r;
  logic [STAT_W-1:0] out_status_r;

  logic              mem_we, mem_re;
  addr_t             mem_wa, mem_ra;
  elem_t             mem_wd, mem_rd;

  logic [ACT_W-1:0]  in_act;
  logic [POS_W-1:0]  in_pos;
  elem_t             in_val;
  logic [POS_W-1:0]  cnt_wide;
  logic              full, empty;
  cnt_t              cur_inc;
  logic              more;
  logic              shift_ok;

  assign in_act   = in_tuser;
  assign in_pos   = in_tdata[POS_W-1:0];
  assign in_val   = in_tdata[POS_W+ELEM_W-1:POS_W];
  assign cnt_wide = POS_W'(cnt_r);
  assign full     = (cnt_r == CNT_W'(CAPACITY));
  assign empty    = (cnt_r == '0);
  // Address following the entry whose data is on the RAM output.
  assign cur_inc  = CNT_W'(rd_addr_r) + CNT_W'(1);
  assign more     = (cur_inc < cnt_r);
  // Insert and push head shift unconditionally; sorted insert only past larger entries.
  assign shift_ok = (act_r != ACT_SORTED) || (val_r < mem_rd);

  assign in_tready = (state_r == S_IDLE);

  iss_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ELEM_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .re    (mem_re),
    .raddr (mem_ra),
    .rdata (mem_rd)
  );

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    act_nxt      = act_r;
    val_nxt      = val_r;
    put_addr_nxt = put_addr_r;
    data_nxt     = data_r;
    status_nxt   = status_r;
    mem_we       = 1'b0;
    mem_wa       = '0;
    mem_wd       = '0;
    mem_re       = 1'b0;
    mem_ra       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt    = in_act;
          val_nxt    = in_val;
          data_nxt   = '0;
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
          case (in_act)
            ACT_INSERT_AT, ACT_PUSH_HEAD, ACT_SORTED: begin
              if (in_act == ACT_INSERT_AT && in_pos > cnt_wide) begin
                status_nxt = ST_RANGE;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else begin
                put_addr_nxt = (in_act == ACT_INSERT_AT) ? in_pos[ADDR_W-1:0] : '0;
                if ((in_act == ACT_INSERT_AT && in_pos == cnt_wide) || empty) begin
                  // Nothing above the slot to move.
                  mem_we  = 1'b1;
                  mem_wa  = cnt_r[ADDR_W-1:0];
                  mem_wd  = in_val;
                  cnt_nxt = cnt_r + CNT_W'(1);
                end else begin
                  mem_re    = 1'b1;
                  mem_ra    = ADDR_W'(cnt_r - CNT_W'(1));
                  state_nxt = S_SHUP;
                end
              end
            end
            ACT_READ: begin
              if (in_pos >= cnt_wide) begin
                status_nxt = ST_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_ra    = in_pos[ADDR_W-1:0];
                state_nxt = S_READ;
              end
            end
            ACT_WRITE: begin
              if (in_pos >= cnt_wide) begin
                status_nxt = ST_RANGE;
              end else begin
                mem_we = 1'b1;
                mem_wa = in_pos[ADDR_W-1:0];
                mem_wd = in_val;
              end
            end
            ACT_PUSH_TAIL: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we  = 1'b1;
                mem_wa  = cnt_r[ADDR_W-1:0];
                mem_wd  = in_val;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            ACT_POP_TAIL: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_ra    = ADDR_W'(cnt_r - CNT_W'(1));
                cnt_nxt   = cnt_r - CNT_W'(1);
                state_nxt = S_READ;
              end
            end
            ACT_POP_HEAD: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_ra    = '0;
                state_nxt = S_READ;
              end
            end
            ACT_DELETE: begin
              if (!empty) begin
                mem_re    = 1'b1;
                mem_ra    = '0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SHUP: begin
        // The entry read last cycle moves up one slot, or the new value
        // lands above it when the sorted scan stops.
        mem_we = 1'b1;
        mem_wa = cur_inc[ADDR_W-1:0];
        if (shift_ok) begin
          mem_wd = mem_rd;
          if (rd_addr_r == put_addr_r) begin
            state_nxt = S_PUT;
          end else begin
            mem_re = 1'b1;
            mem_ra = rd_addr_r - ADDR_W'(1);
          end
        end else begin
          mem_wd    = val_r;
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = S_DONE;
        end
      end

      S_PUT: begin
        mem_we    = 1'b1;
        mem_wa    = put_addr_r;
        mem_wd    = val_r;
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = S_DONE;
      end

      S_READ: begin
        data_nxt = mem_rd;
        if (act_r == ACT_POP_HEAD) begin
          if (more) begin
            mem_re    = 1'b1;
            mem_ra    = cur_inc[ADDR_W-1:0];
            state_nxt = S_SHDN;
          end else begin
            cnt_nxt   = cnt_r - CNT_W'(1);
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_SCAN: begin
        if (mem_rd == val_r) begin
          data_nxt = mem_rd;
          if (more) begin
            mem_re    = 1'b1;
            mem_ra    = cur_inc[ADDR_W-1:0];
            state_nxt = S_SHDN;
          end else begin
            cnt_nxt   = cnt_r - CNT_W'(1);
            state_nxt = S_DONE;
          end
        end else if (more) begin
          mem_re = 1'b1;
          mem_ra = cur_inc[ADDR_W-1:0];
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_SHDN: begin
        // Close the gap: the entry read last cycle moves down one slot.
        mem_we = 1'b1;
        mem_wa = rd_addr_r - ADDR_W'(1);
        mem_wd = mem_rd;
        if (more) begin
          mem_re = 1'b1;
          mem_ra = cur_inc[ADDR_W-1:0];
        end else begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    val_r      <= val_nxt;
    put_addr_r <= put_addr_nxt;
    data_r     <= data_nxt;
    status_r   <= status_nxt;
    if (mem_re) begin
      rd_addr_r <= mem_ra;
    end
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_data_r   <= data_r;
      out_cnt_r    <= cnt_r;
      out_status_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_cnt_r, out_data_r};
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

// ----- hdl/iss_ram.sv -----
// ----------------------------------------------------------------------------
// iss_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered, so it
// appears in the cycle after the read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module iss_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
